// File: design/mexp_pkg.sv
`timescale 1ns / 1ps
package mexp_pkg;

  localparam int unsigned WORD_W = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDS,
    ST_RED,
    ST_SCAN,
    ST_LOOP,
    ST_SQ,
    ST_MULS,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    MSEL_REDUCE,
    MSEL_SQUARE,
    MSEL_MULT
  } msel_t;

  typedef struct packed {
    logic  load;
    logic  mul_start;
    msel_t msel;
    logic  acc_from_x;
    logic  acc_from_one;
    logic  acc_from_mul;
    logic  x_from_mul;
    logic  exp_shift;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic exp_msb;
    logic cnt_zero;
  } sts_t;

endpackage

// File: design/mexp_mulmod.sv
`timescale 1ns / 1ps
module mexp_mulmod (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [mexp_pkg::WORD_W-1:0]    op_a,
  input  logic [mexp_pkg::WORD_W-1:0]    op_b,
  input  logic [mexp_pkg::WORD_W-1:0]    modulus,
  output logic                           done,
  output logic [mexp_pkg::WORD_W-1:0]    result
);
  import mexp_pkg::*;

  localparam int unsigned CNT_W = $clog2(WORD_W);

  logic [WORD_W-1:0] a_r, a_nxt;
  logic [WORD_W-1:0] b_r, b_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;

  logic [WORD_W:0] m_ext;
  logic [WORD_W:0] dbl;
  logic [WORD_W:0] dbl_red;
  logic [WORD_W:0] sum;
  logic [WORD_W:0] sum_red;

  // one bit of a per cycle, msb first: acc = 2*acc + a_bit*b, reduced twice
  always_comb begin
    m_ext   = {1'b0, modulus};
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
    sum     = {1'b0, dbl_red[WORD_W-1:0]} + {1'b0, (a_r[WORD_W-1] ? b_r : '0)};
    sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt   = op_a;
      b_nxt   = op_b;
      acc_nxt = '0;
      cnt_nxt = CNT_W'(WORD_W - 1);
      run_nxt = 1'b1;
    end else if (run_r) begin
      acc_nxt = sum_red[WORD_W-1:0];
      a_nxt   = {a_r[WORD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

// File: design/mexp_dp.sv
`timescale 1ns / 1ps
module mexp_dp #(
  parameter int unsigned EXP_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [3*mexp_pkg::WORD_W-1:0]   in_data,
  input  mexp_pkg::cmd_t                  cmd,
  output mexp_pkg::sts_t                  sts,
  output logic [mexp_pkg::WORD_W-1:0]     out_data
);
  import mexp_pkg::*;

  localparam int unsigned CNT_W = $clog2(EXP_BITS + 1);

  logic [WORD_W-1:0]   base_r, m_r, one_r, x_r, acc_r, res_r;
  logic [EXP_BITS-1:0] exp_r;
  logic [CNT_W-1:0]    cnt_r;

  logic [WORD_W-1:0] in_base, in_exp, in_mod, mag;
  logic [WORD_W-1:0] op_a, op_b, mul_res;
  logic              mul_done;

  assign in_base = in_data[WORD_W-1:0];
  assign in_exp  = in_data[2*WORD_W-1:WORD_W];
  assign in_mod  = in_data[3*WORD_W-1:2*WORD_W];
  assign mag     = in_exp[WORD_W-1] ? (~in_exp + 1'b1) : in_exp;

  always_comb begin
    case (cmd.msel)
      MSEL_REDUCE: begin
        op_a = base_r;
        op_b = one_r;
      end
      MSEL_SQUARE: begin
        op_a = acc_r;
        op_b = acc_r;
      end
      MSEL_MULT: begin
        op_a = acc_r;
        op_b = x_r;
      end
      default: begin
        op_a = acc_r;
        op_b = x_r;
      end
    endcase
  end

  mexp_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.mul_start),
    .op_a    (op_a),
    .op_b    (op_b),
    .modulus (m_r),
    .done    (mul_done),
    .result  (mul_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= CNT_W'(EXP_BITS);
    end else if (cmd.exp_shift) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r <= in_base;
      m_r    <= in_mod;
      // 1 mod m, used for the base reduction and for a zero exponent
      one_r  <= (in_mod == WORD_W'(1)) ? '0 : WORD_W'(1);
      exp_r  <= mag[EXP_BITS-1:0];
    end else if (cmd.exp_shift) begin
      exp_r  <= {exp_r[EXP_BITS-2:0], 1'b0};
    end
    if (cmd.x_from_mul) begin
      x_r <= mul_res;
    end
    if (cmd.acc_from_x) begin
      acc_r <= x_r;
    end else if (cmd.acc_from_one) begin
      acc_r <= one_r;
    end else if (cmd.acc_from_mul) begin
      acc_r <= mul_res;
    end
    if (cmd.out_load) begin
      res_r <= (m_r == '0) ? '0 : acc_r;
    end
  end

  assign sts.mul_done = mul_done;
  assign sts.exp_msb  = exp_r[EXP_BITS-1];
  assign sts.cnt_zero = (cnt_r == '0);
  assign out_data     = res_r;

endmodule

// File: design/mexp_ctrl.sv
`timescale 1ns / 1ps
module mexp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  mexp_pkg::sts_t sts,
  output mexp_pkg::cmd_t cmd
);
  import mexp_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.msel  = MSEL_REDUCE;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_REDS;
        end
      end
      ST_REDS: begin
        cmd.mul_start = 1'b1;
        cmd.msel      = MSEL_REDUCE;
        state_nxt     = ST_RED;
      end
      ST_RED: begin
        if (sts.mul_done) begin
          cmd.x_from_mul = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      // walk down to the leading one of the exponent
      ST_SCAN: begin
        if (sts.cnt_zero) begin
          cmd.acc_from_one = 1'b1;
          state_nxt        = ST_FIN;
        end else if (sts.exp_msb) begin
          cmd.acc_from_x = 1'b1;
          cmd.exp_shift  = 1'b1;
          state_nxt      = ST_LOOP;
        end else begin
          cmd.exp_shift = 1'b1;
        end
      end
      ST_LOOP: begin
        if (sts.cnt_zero) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.msel      = MSEL_SQUARE;
          state_nxt     = ST_SQ;
        end
      end
      ST_SQ: begin
        if (sts.mul_done) begin
          cmd.acc_from_mul = 1'b1;
          if (sts.exp_msb) begin
            state_nxt = ST_MULS;
          end else begin
            cmd.exp_shift = 1'b1;
            state_nxt     = ST_LOOP;
          end
        end
      end
      ST_MULS: begin
        cmd.mul_start = 1'b1;
        cmd.msel      = MSEL_MULT;
        state_nxt     = ST_MUL;
      end
      ST_MUL: begin
        if (sts.mul_done) begin
          cmd.acc_from_mul = 1'b1;
          cmd.exp_shift    = 1'b1;
          state_nxt        = ST_LOOP;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// File: design/modular_exponentiation_core.sv
`timescale 1ns / 1ps
// channel | direction | tdata fields (lowest bit up)
// in_     | slave     | base_value[31:0], exponent_value[63:32], modulus_value[95:64]
// out_    | master    | power_result[31:0]
//
// one item at a time; after the base reduction, each exponent bit below the leading one
// of the magnitude costs a square, and each set bit among them also a multiply;
// each product runs in the bit-serial multiply-reduce unit as a start, 32 bit steps and a done
// in_tready is high only while idle; a finished result waits in the output register
// and the next item is taken while it waits
// synchronous active-low reset clears the controller and the output valid flag
module modular_exponentiation_core #(
  parameter int unsigned EXP_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // base_value, exponent_value, modulus_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // power_result
);
  import mexp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mexp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mexp_dp #(
    .EXP_BITS (EXP_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_tdata)
  );

endmodule

// File: design/mexp_chk.sv
`timescale 1ns / 1ps
module mexp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // the base reduction alone keeps the block busy for many cycles
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready ##1 !in_tready)
    else $error("new item taken while one is in progress");

  // a result only appears as the block returns to idle
  a_result_with_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result raised while still computing");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset did not return block to idle");

endmodule

bind modular_exponentiation_core mexp_chk u_mexp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
